FILE: src/c2jd_pkg.sv
`timescale 1ns / 1ps
// c2jd_pkg: widths, constants, month tables and stage word types for the
// calendar date to Julian date pipeline. No dependencies.
package c2jd_pkg;

    // Fixed point position of the seconds fields
    localparam int SECOND_FRAC_BITS = 20;

    // Port field widths
    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SEC_W    = 26;
    localparam int ERR_W    = 3;
    localparam int WHOLE_W  = 23;
    localparam int SINCE_W  = 37;

    // Time of day: whole seconds up to 86340 need 17 bits, plus one for the noon shift
    localparam int HMS_W     = 17;
    localparam int TOD_W     = SECOND_FRAC_BITS + HMS_W + 1;
    localparam int SEC_CMP_W = (SECOND_FRAC_BITS + 6 > SEC_W) ? SECOND_FRAC_BITS + 6 : SEC_W;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam logic [SEC_CMP_W-1:0] SEC_LIMIT = SEC_CMP_W'(60) << SECOND_FRAC_BITS;
    localparam logic [TOD_W-1:0]     HALF_DAY  = TOD_W'(43200) << SECOND_FRAC_BITS;

    localparam logic [HOUR_W-1:0]   NOON_HOUR  = HOUR_W'(12);
    localparam logic [HOUR_W-1:0]   MAX_HOUR   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MAX_MINUTE = MINUTE_W'(59);
    localparam logic [MONTH_W-1:0]  MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0]  MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0]  MONTH_DEC  = MONTH_W'(12);

    // Year bias: a multiple of 400 that keeps every year non-negative, so the
    // century terms need only unsigned division. The date term uses the year
    // shifted by 4800, which stays a multiple of 400 away from the same bias.
    localparam int U_W = 16;
    localparam logic [U_W-1:0] YEAR_OFS = U_W'(16400);

    // Division by 25 through reciprocal multiply, exact for dividends below 43690
    localparam int DIV_MUL_W = 13;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(5243);
    localparam int DIV_SHIFT = 17;
    localparam int DIV_DEN   = 25;
    localparam int D100_W    = U_W - 2;
    localparam int D400_W    = U_W - 4;
    localparam int P100_W    = D100_W + DIV_MUL_W;
    localparam int P400_W    = D400_W + DIV_MUL_W;
    localparam int Q100_W    = P100_W - DIV_SHIFT;
    localparam int Q400_W    = P400_W - DIV_SHIFT;

    // Day number assembly: 365 * (y + 11600) + ... minus this bias gives the JDN
    localparam int YEAR_DAYS = 365;
    localparam int JDN_BIAS  = 4268858;

    localparam int OFS_W = 9;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 3'd0,
        ERR_MONTH  = 3'd1,
        ERR_DAY    = 3'd2,
        ERR_HOUR   = 3'd3,
        ERR_MINUTE = 3'd4,
        ERR_SECOND = 3'd5
    } t_err;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SEC_W-1:0]         sec;
    } t_in;

    typedef struct packed {
        logic               err_month;
        logic               err_hour;
        logic               err_minute;
        logic               err_sec;
        logic               is_feb;
        logic [DAY_W-1:0]   len_base;
        logic [U_W-1:0]     u;
        logic [U_W-1:0]     u_y;
        logic [P100_W-1:0]  p100u;
        logic [P400_W-1:0]  p400u;
        logic [P100_W-1:0]  p100y;
        logic [P400_W-1:0]  p400y;
        logic [OFS_W-1:0]   ofs;
        logic [DAY_W-1:0]   day;
        logic [HMS_W-1:0]   hms;
        logic [SEC_W-1:0]   sec;
        logic               morning;
    } t_s1;

    typedef struct packed {
        t_err               err;
        logic [WHOLE_W-1:0] part_a;
        logic [WHOLE_W-1:0] part_b;
        logic [TOD_W-1:0]   tod;
        logic               morning;
    } t_s2;

    typedef struct packed {
        t_err               err;
        logic [WHOLE_W-1:0] whole;
        logic [SINCE_W-1:0] since;
    } t_res;

    // Days from 1 March to the first of the month, year starting in March
    function automatic logic [OFS_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [OFS_W-1:0] ofs;
        case (month)
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            default: ofs = '0;
        endcase
        return ofs;
    endfunction

    // Month length in a common year
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:                   len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                len = '0;
        endcase
        return len;
    endfunction

endpackage

FILE: src/c2jd_prep.sv
`timescale 1ns / 1ps
// c2jd_prep: first pipeline stage; range checks, biased year, reciprocal
// products for the century terms and the time of day in seconds. Uses c2jd_pkg.
module c2jd_prep import c2jd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_valid,
    output t_s1  o_data
);

    logic           r_valid;
    t_s1            r_data;
    t_s1            n_data;
    logic           march_shift;
    logic [U_W-1:0] u;

    always_comb begin
        // January and February count as months 11 and 12 of the previous year
        march_shift = (i_data.month == MONTH_JAN) || (i_data.month == MONTH_FEB);
        u = YEAR_OFS + {{(U_W - YEAR_W){i_data.year[YEAR_W-1]}}, i_data.year};

        n_data.err_month  = (i_data.month == '0) || (i_data.month > MONTH_DEC);
        n_data.err_hour   = i_data.hour > MAX_HOUR;
        n_data.err_minute = i_data.minute > MAX_MINUTE;
        n_data.err_sec    = SEC_CMP_W'(i_data.sec) >= SEC_LIMIT;
        n_data.is_feb     = i_data.month == MONTH_FEB;
        n_data.len_base   = month_length(i_data.month);
        n_data.u          = u;
        n_data.u_y        = u - U_W'(march_shift);
        n_data.p100u      = P100_W'(u[U_W-1:2]) * P100_W'(DIV_MUL);
        n_data.p400u      = P400_W'(u[U_W-1:4]) * P400_W'(DIV_MUL);
        n_data.p100y      = P100_W'(n_data.u_y[U_W-1:2]) * P100_W'(DIV_MUL);
        n_data.p400y      = P400_W'(n_data.u_y[U_W-1:4]) * P400_W'(DIV_MUL);
        n_data.ofs        = month_offset(i_data.month);
        n_data.day        = i_data.day;
        n_data.hms        = HMS_W'(i_data.hour) * HMS_W'(SEC_PER_HOUR)
                          + HMS_W'(i_data.minute) * HMS_W'(SEC_PER_MIN);
        n_data.sec        = i_data.sec;
        n_data.morning    = i_data.hour < NOON_HOUR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/c2jd_check.sv
`timescale 1ns / 1ps
// c2jd_check: second pipeline stage; leap rule, error priority, partial day
// number sums and fixed point time of day. Uses c2jd_pkg.
module c2jd_check import c2jd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s1  i_data,
    output logic o_valid,
    output t_s2  o_data
);

    logic              r_valid;
    t_s2               r_data;
    t_s2               n_data;
    logic [Q100_W-1:0] q100u;
    logic [Q400_W-1:0] q400u;
    logic [Q100_W-1:0] q100y;
    logic [Q400_W-1:0] q400y;
    logic [D100_W:0]   m100u;
    logic [D400_W:0]   m400u;
    logic              div100;
    logic              div400;
    logic              leap;
    logic [DAY_W-1:0]  len;

    always_comb begin
        q100u = i_data.p100u[P100_W-1:DIV_SHIFT];
        q400u = i_data.p400u[P400_W-1:DIV_SHIFT];
        q100y = i_data.p100y[P100_W-1:DIV_SHIFT];
        q400y = i_data.p400y[P400_W-1:DIV_SHIFT];

        // Remainder zero when quotient times 25 gives back the dividend
        m100u  = (D100_W + 1)'(q100u) * (D100_W + 1)'(DIV_DEN);
        m400u  = (D400_W + 1)'(q400u) * (D400_W + 1)'(DIV_DEN);
        div100 = (i_data.u[1:0] == 2'b00) && ({1'b0, i_data.u[U_W-1:2]} == m100u);
        div400 = (i_data.u[3:0] == 4'b0000) && ({1'b0, i_data.u[U_W-1:4]} == m400u);
        leap   = ((i_data.u[1:0] == 2'b00) && !div100) || div400;
        len    = i_data.len_base + DAY_W'(i_data.is_feb && leap);

        if (i_data.err_month) begin
            n_data.err = ERR_MONTH;
        end else if ((i_data.day == '0) || (i_data.day > len)) begin
            n_data.err = ERR_DAY;
        end else if (i_data.err_hour) begin
            n_data.err = ERR_HOUR;
        end else if (i_data.err_minute) begin
            n_data.err = ERR_MINUTE;
        end else if (i_data.err_sec) begin
            n_data.err = ERR_SECOND;
        end else begin
            n_data.err = ERR_NONE;
        end

        // Day number terms, kept modulo the output width
        n_data.part_a  = WHOLE_W'(i_data.u_y) * WHOLE_W'(YEAR_DAYS)
                       + WHOLE_W'(i_data.u_y[U_W-1:2]);
        n_data.part_b  = WHOLE_W'(i_data.day) + WHOLE_W'(i_data.ofs)
                       - WHOLE_W'(q100y) + WHOLE_W'(q400y);
        n_data.tod     = (TOD_W'(i_data.hms) << SECOND_FRAC_BITS) + TOD_W'(i_data.sec);
        n_data.morning = i_data.morning;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/c2jd_sum.sv
`timescale 1ns / 1ps
// c2jd_sum: last pipeline stage and output register; final day number, noon
// split and zeroing of erroneous words. Uses c2jd_pkg.
module c2jd_sum import c2jd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_s2  i_data,
    output logic o_valid,
    output t_res o_data
);

    logic               r_valid;
    t_res               r_data;
    t_res               n_data;
    logic [WHOLE_W-1:0] whole;
    logic [TOD_W-1:0]   since;

    always_comb begin
        // A morning belongs to the Julian day that began the previous noon
        whole = i_data.part_a + i_data.part_b - WHOLE_W'(JDN_BIAS)
              - WHOLE_W'(i_data.morning);
        since = i_data.morning ? (i_data.tod + HALF_DAY) : (i_data.tod - HALF_DAY);

        n_data.err = i_data.err;
        if (i_data.err == ERR_NONE) begin
            n_data.whole = whole;
            n_data.since = SINCE_W'(since);
        end else begin
            n_data.whole = '0;
            n_data.since = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/calendar_to_julian_date.sv
`timescale 1ns / 1ps
// calendar_to_julian_date: top level; Gregorian date and time to Julian date.
// Instantiates c2jd_prep, c2jd_check and c2jd_sum; uses c2jd_pkg.
//
//  channel | handshake         | word
//  --------+-------------------+-----------------------------------------------
//  input   | i_valid / o_ready | i_year i_month i_day i_hour i_minute i_second_fixed
//  output  | o_valid / i_ready | o_error_code o_julian_whole o_seconds_since_noon
//
// One word per cycle sustained while the output is not stalled; three register
// stages (checks and products, leap rule and partial sums, final sum).
// Reset clears the stage valid bits only; data registers are not reset.
// A stalled output holds in the last stage; earlier stages keep moving into
// empty slots, and o_ready falls only when all three stages are full and
// the output is stalled.
module calendar_to_julian_date import c2jd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [YEAR_W-1:0] i_year,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic [HOUR_W-1:0]        i_hour,
    input  logic [MINUTE_W-1:0]      i_minute,
    input  logic [SEC_W-1:0]         i_second_fixed,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ERR_W-1:0]         o_error_code,
    output logic [WHOLE_W-1:0]       o_julian_whole,
    output logic [SINCE_W-1:0]       o_seconds_since_noon
);

    t_in  in_word;
    t_s1  s1_word;
    t_s2  s2_word;
    t_res res_word;
    logic s1_valid;
    logic s2_valid;
    logic s3_valid;
    logic en1;
    logic en2;
    logic en3;

    assign in_word.year   = i_year;
    assign in_word.month  = i_month;
    assign in_word.day    = i_day;
    assign in_word.hour   = i_hour;
    assign in_word.minute = i_minute;
    assign in_word.sec    = i_second_fixed;

    // Advance a stage when it is empty or the one after it advances
    assign en3 = !s3_valid || i_ready;
    assign en2 = !s2_valid || en3;
    assign en1 = !s1_valid || en2;

    c2jd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_valid),
        .i_data  (in_word),
        .o_valid (s1_valid),
        .o_data  (s1_word)
    );

    c2jd_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_data  (s1_word),
        .o_valid (s2_valid),
        .o_data  (s2_word)
    );

    c2jd_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (s2_valid),
        .i_data  (s2_word),
        .o_valid (s3_valid),
        .o_data  (res_word)
    );

    assign o_ready              = en1;
    assign o_valid              = s3_valid;
    assign o_error_code         = res_word.err;
    assign o_julian_whole       = res_word.whole;
    assign o_seconds_since_noon = res_word.since;

`ifndef SYNTHESIS
    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_error_zeroes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_error_code != ERR_NONE)) |->
            ((o_julian_whole == '0) && (o_seconds_since_noon == '0)))
        else $error("erroneous word carries non-zero result fields");

    a_ready_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (s1_valid && s2_valid && s3_valid && !i_ready))
        else $error("input held off with a free pipeline slot");
`endif

endmodule

FILE: sim/julian_date_checker.sv
`timescale 1ns / 1ps
// julian_date_checker: watches both channels of calendar_to_julian_date, works
// out the expected Julian date of every accepted word and compares results.
// Uses c2jd_pkg for widths, the error codes and the word types.
module julian_date_checker import c2jd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic signed [YEAR_W-1:0] i_year,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic [HOUR_W-1:0]        i_hour,
    input  logic [MINUTE_W-1:0]      i_minute,
    input  logic [SEC_W-1:0]         i_second_fixed,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [ERR_W-1:0]         i_error_code,
    input  logic [WHOLE_W-1:0]       i_julian_whole,
    input  logic [SINCE_W-1:0]       i_seconds_since_noon,
    output int                       o_pending,
    output int                       o_fail_count
);

    t_res expected_dates[$];
    int   fail_count = 0;
    int   words_seen = 0;

    assign o_fail_count = fail_count;

    // Quotient rounded towards minus infinity
    function automatic int floor_quot(input int num, input int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic t_res julian_of(input t_in d);
        t_res        r;
        int          yr;
        int          mo;
        int          dy;
        int          len;
        int          a;
        int          y;
        int          m;
        int          jdn;
        int          whole;
        logic [31:0] whole_bits;
        logic [63:0] tod;
        logic [63:0] half;
        logic [63:0] since;
        bit          leap;
        r    = '0;
        yr   = {{(32-YEAR_W){d.year[YEAR_W-1]}}, d.year};
        mo   = int'(d.month);
        dy   = int'(d.day);
        leap = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        case (mo)
            2:             len = leap ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        if (mo < 1 || mo > 12)
            r.err = ERR_MONTH;
        else if (dy < 1 || dy > len)
            r.err = ERR_DAY;
        else if (d.hour > 23)
            r.err = ERR_HOUR;
        else if (d.minute > 59)
            r.err = ERR_MINUTE;
        else if (64'(d.sec) >= (64'd60 << SECOND_FRAC_BITS))
            r.err = ERR_SECOND;
        else
            r.err = ERR_NONE;
        if (r.err != ERR_NONE)
            return r;

        a   = (14 - mo) / 12;
        y   = yr + 4800 - a;
        m   = mo + 12 * a - 3;
        jdn = dy + (153 * m + 2) / 5 + 365 * y
              + floor_quot(y, 4) - floor_quot(y, 100) + floor_quot(y, 400) - 32045;
        tod  = ((64'(d.hour) * 64'd3600 + 64'(d.minute) * 64'd60) << SECOND_FRAC_BITS)
               + 64'(d.sec);
        half = 64'd43200 << SECOND_FRAC_BITS;
        // morning belongs to the Julian day that began at the previous noon
        if (tod < half) begin
            whole = jdn - 1;
            since = tod + half;
        end else begin
            whole = jdn;
            since = tod - half;
        end
        whole_bits = whole;
        r.whole    = whole_bits[WHOLE_W-1:0];
        r.since    = since[SINCE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("date word %0d: %s got %0d want %0d", words_seen, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_in  d;
        t_res want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                d.year   = i_year;
                d.month  = i_month;
                d.day    = i_day;
                d.hour   = i_hour;
                d.minute = i_minute;
                d.sec    = i_second_fixed;
                expected_dates.push_back(julian_of(d));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("word with nothing pending, error code",
                                    64'(i_error_code), 64'd0);
                end else begin
                    want = expected_dates.pop_front();
                    if (i_error_code !== want.err)
                        report_mismatch("error code", 64'(i_error_code), 64'(want.err));
                    if (i_julian_whole !== want.whole)
                        report_mismatch("julian whole", 64'(i_julian_whole),
                                        64'(want.whole));
                    if (i_seconds_since_noon !== want.since)
                        report_mismatch("seconds since noon", 64'(i_seconds_since_noon),
                                        64'(want.since));
                end
                words_seen++;
            end
        end
        o_pending <= expected_dates.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// tb: drives calendar_to_julian_date with directed and random dates under
// several idle and stall patterns; julian_date_checker does the comparing.
// Depends on c2jd_pkg, calendar_to_julian_date and julian_date_checker.
module tb;
    import c2jd_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int SEC_VALID_MAX = (60 << SECOND_FRAC_BITS) - 1;
    localparam int PHASE_WORDS   = 225;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [YEAR_W-1:0] i_year;
    logic [MONTH_W-1:0]       i_month;
    logic [DAY_W-1:0]         i_day;
    logic [HOUR_W-1:0]        i_hour;
    logic [MINUTE_W-1:0]      i_minute;
    logic [SEC_W-1:0]         i_second_fixed;
    logic                     o_valid;
    logic                     i_ready;
    logic [ERR_W-1:0]         o_error_code;
    logic [WHOLE_W-1:0]       o_julian_whole;
    logic [SINCE_W-1:0]       o_seconds_since_noon;

    int pending;
    int fail_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;
    bit hold_done      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    calendar_to_julian_date u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_year               (i_year),
        .i_month              (i_month),
        .i_day                (i_day),
        .i_hour               (i_hour),
        .i_minute             (i_minute),
        .i_second_fixed       (i_second_fixed),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_error_code         (o_error_code),
        .o_julian_whole       (o_julian_whole),
        .o_seconds_since_noon (o_seconds_since_noon)
    );

    julian_date_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_valid),
        .i_in_ready           (o_ready),
        .i_year               (i_year),
        .i_month              (i_month),
        .i_day                (i_day),
        .i_hour               (i_hour),
        .i_minute             (i_minute),
        .i_second_fixed       (i_second_fixed),
        .i_out_valid          (o_valid),
        .i_out_ready          (i_ready),
        .i_error_code         (o_error_code),
        .i_julian_whole       (o_julian_whole),
        .i_seconds_since_noon (o_seconds_since_noon),
        .o_pending            (pending),
        .o_fail_count         (fail_count)
    );

    // Receiver: random stalls, or one long hold-off when asked
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: give up after too many cycles with no word moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one date word and hold it until accepted; valid stays high afterwards
    task automatic push_date(input logic signed [YEAR_W-1:0] yr,
                             input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] dy,
                             input logic [HOUR_W-1:0] hr, input logic [MINUTE_W-1:0] mi,
                             input logic [SEC_W-1:0] sc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_year         <= yr;
        i_month        <= mo;
        i_day          <= dy;
        i_hour         <= hr;
        i_minute       <= mi;
        i_second_fixed <= sc;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // Mostly well-formed dates, with edges near noon and month ends, plus noise
    task automatic push_random_date();
        int mode;
        int yr;
        int dy;
        int hr;
        int mi;
        mode = $urandom_range(99);
        if (mode < 15) begin
            push_date(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
                      HOUR_W'($urandom), MINUTE_W'($urandom), SEC_W'($urandom));
        end else begin
            yr = (mode < 25) ? int'($urandom) : int'($urandom_range(14699)) - 4700;
            dy = ($urandom_range(3) != 0) ? $urandom_range(28, 1) : $urandom_range(31, 29);
            hr = $urandom_range(23);
            mi = $urandom_range(59);
            if ($urandom_range(9) == 0) begin
                hr = $urandom_range(1) ? 12 : 11;
                mi = $urandom_range(1) ? 59 : 0;
            end
            push_date(YEAR_W'(yr), MONTH_W'($urandom_range(12, 1)), DAY_W'(dy),
                      HOUR_W'(hr), MINUTE_W'(mi), SEC_W'($urandom_range(SEC_VALID_MAX)));
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int words);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (words) push_random_date();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_year         = '0;
        i_month        = '0;
        i_day          = '0;
        i_hour         = '0;
        i_minute       = '0;
        i_second_fixed = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the year range, including wrap of a negative Julian date
        push_date(-4700, 1, 1, 12, 0, 0);
        push_date(9999, 12, 31, 23, 59, SEC_VALID_MAX);
        push_date(-16384, 3, 1, 0, 0, 0);
        push_date(16383, 12, 31, 11, 59, SEC_VALID_MAX);
        // leap rule, negative years included
        push_date(2000, 2, 29, 12, 0, 0);
        push_date(1900, 2, 29, 12, 0, 0);
        push_date(0, 2, 29, 6, 30, 0);
        push_date(-100, 2, 29, 0, 0, 0);
        push_date(-400, 2, 29, 0, 0, 0);
        // each error, and the first failing field winning
        push_date(2024, 0, 10, 10, 0, 0);
        push_date(2024, 13, 10, 10, 0, 0);
        push_date(2024, 15, 10, 10, 0, 0);
        push_date(2024, 4, 31, 10, 0, 0);
        push_date(2024, 1, 0, 10, 0, 0);
        push_date(2024, 1, 31, 10, 0, 0);
        push_date(2024, 5, 5, 24, 0, 0);
        push_date(2024, 5, 5, 31, 63, 0);
        push_date(2024, 5, 5, 5, 60, 0);
        push_date(2024, 5, 5, 5, 63, 67108863);
        push_date(2024, 5, 5, 5, 5, SEC_VALID_MAX + 1);
        push_date(2024, 5, 5, 5, 5, 67108863);
        push_date(2024, 0, 0, 31, 63, 67108863);
        // either side of noon, and midnight
        push_date(2024, 6, 15, 11, 59, SEC_VALID_MAX);
        push_date(2024, 6, 15, 12, 0, 0);
        push_date(2024, 6, 15, 0, 0, 0);

        // long receiver hold-off while words keep coming, so the input stalls
        hold_off = 1'b1;
        run_phase(0, 0, 40);
        run_phase(0, 0, PHASE_WORDS - 40);
        run_phase(60, 0, PHASE_WORDS);
        run_phase(0, 60, PHASE_WORDS);
        run_phase(24, 24, PHASE_WORDS);
        i_valid <= 1'b0;
        // let the checker count the last accepted word before polling
        @(posedge i_clk);

        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
